### src/arabic_persian_contextual_shaper_macros.svh
// Assertion macros used by the checker module.
// Each macro checks a property on the rising edge of clk, and is off while rst_n is low.
`ifndef ARABIC_PERSIAN_CONTEXTUAL_SHAPER_MACROS_SVH
`define ARABIC_PERSIAN_CONTEXTUAL_SHAPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APCS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apcs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define APCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apcs assertion failed");

`endif

### src/apcs_pkg.sv
// ----------------------------------------------------------------------------
// apcs_pkg
// Types, the glyph table and the helper functions of the contextual shaper.
// ----------------------------------------------------------------------------
package apcs_pkg;

    localparam logic [7:0] CodeSpace = 8'd32;
    localparam logic [7:0] CodeOffset = 8'd32;
    localparam int MaxWords = 6;

    // The forms of one glyph, as a selector into a glyph-table row.
    typedef enum logic [1:0] {
        FORM_ISOLATED = 2'd0,
        FORM_INITIAL  = 2'd1,
        FORM_MEDIAL   = 2'd2,
        FORM_FINAL    = 2'd3
    } form_t;

    // One shaped character: its UTF-8 bytes, the first byte in slot 0.
    typedef struct packed {
        logic            hit;
        logic [1:0]      len;
        logic [2:0][7:0] bytes;
    } shaped_t;

    // One queue entry: every output word that one input word causes.
    typedef struct packed {
        logic [2:0]               count;
        logic [MaxWords-1:0][7:0] bytes;
        logic [MaxWords-1:0]      lasts;
        logic                     done;
    } apcs_entry_t;

    function automatic logic [7:0] decode_pair(input logic [7:0] lead, input logic [7:0] trail);
        logic [7:0] t;
        logic [7:0] c;
        logic       gsel;
        t    = lead + CodeOffset;
        c    = trail + CodeOffset;
        gsel = (t == 8'd218) || (t == 8'd250);
        if (c == 8'd207)
        begin
            if (gsel)
            begin
                c = 8'd144;
            end
        end
        else if (c == 8'd166)
        begin
            c = gsel ? 8'd141 : 8'd228;
        end
        if ((c == 8'd172) && ((t == 8'd248) || (t == CodeSpace)))
        begin
            c = 8'd44;
        end
        return c;
    endfunction

    // Characters after which the next one starts a new joined run.
    function automatic logic in_set1(input logic [7:0] c);
        unique case (c)
            8'd32, 8'd0, 8'd199, 8'd194, 8'd207, 8'd208, 8'd209, 8'd210, 8'd184,
            8'd168, 8'd191, 8'd40, 8'd41, 8'd46, 8'd33, 8'd44, 8'd58, 8'd248: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Characters before which the current one ends its joined run.
    function automatic logic in_set2(input logic [7:0] c);
        unique case (c)
            8'd32, 8'd0, 8'd191, 8'd40, 8'd41, 8'd46, 8'd33, 8'd44, 8'd58,
            8'd248: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Glyph table. The result packs the isolated, initial, medial and final
    // forms from the top down; bit 64 is set when the code is in the table.
    // Teh marbuta decodes to code 201, which has a row, so it matches.
    function automatic logic [64:0] glyph_row(input logic [7:0] code);
        unique case (code)
            8'd193: return {1'b1, 16'hFE80, 16'hFE80, 16'hFE80, 16'hFE80};
            8'd194: return {1'b1, 16'hFE81, 16'hFE81, 16'hFE82, 16'hFE82};
            8'd195: return {1'b1, 16'hFE83, 16'hFE83, 16'hFE84, 16'hFE84};
            8'd196: return {1'b1, 16'hFE85, 16'hFE85, 16'hFE86, 16'hFE86};
            8'd197: return {1'b1, 16'hFE87, 16'hFE87, 16'hFE88, 16'hFE88};
            8'd198: return {1'b1, 16'hFE89, 16'hFE8B, 16'hFE8C, 16'hFE8A};
            8'd199: return {1'b1, 16'hFE8D, 16'hFE8D, 16'hFE8E, 16'hFE8E};
            8'd200: return {1'b1, 16'hFE8F, 16'hFE91, 16'hFE92, 16'hFE90};
            8'd202: return {1'b1, 16'hFE95, 16'hFE97, 16'hFE98, 16'hFE96};
            8'd203: return {1'b1, 16'hFE99, 16'hFE9B, 16'hFE9C, 16'hFE9A};
            8'd204: return {1'b1, 16'hFE9D, 16'hFE9F, 16'hFEA0, 16'hFE9E};
            8'd205: return {1'b1, 16'hFEA1, 16'hFEA3, 16'hFEA4, 16'hFEA2};
            8'd206: return {1'b1, 16'hFEA5, 16'hFEA7, 16'hFEA8, 16'hFEA6};
            8'd207: return {1'b1, 16'hFEA9, 16'hFEA9, 16'hFEAA, 16'hFEAA};
            8'd208: return {1'b1, 16'hFEAB, 16'hFEAB, 16'hFEAC, 16'hFEAC};
            8'd209: return {1'b1, 16'hFEAD, 16'hFEAD, 16'hFEAE, 16'hFEAE};
            8'd210: return {1'b1, 16'hFEAF, 16'hFEAF, 16'hFEB0, 16'hFEB0};
            8'd184: return {1'b1, 16'hFB8A, 16'hFB8A, 16'hFB8B, 16'hFB8B};
            8'd211: return {1'b1, 16'hFEB1, 16'hFEB3, 16'hFEB4, 16'hFEB2};
            8'd212: return {1'b1, 16'hFEB5, 16'hFEB7, 16'hFEB8, 16'hFEB6};
            8'd213: return {1'b1, 16'hFEB9, 16'hFEBB, 16'hFEBC, 16'hFEBA};
            8'd214: return {1'b1, 16'hFEBD, 16'hFEBF, 16'hFEC0, 16'hFEBE};
            8'd215: return {1'b1, 16'hFEC1, 16'hFEC3, 16'hFEC4, 16'hFEC2};
            8'd216: return {1'b1, 16'hFEC5, 16'hFEC7, 16'hFEC8, 16'hFEC6};
            8'd217: return {1'b1, 16'hFEC9, 16'hFECB, 16'hFECC, 16'hFECA};
            8'd218: return {1'b1, 16'hFECD, 16'hFECF, 16'hFED0, 16'hFECE};
            8'd160: return {1'b1, 16'h0640, 16'h0640, 16'h0640, 16'h0640};
            8'd161: return {1'b1, 16'hFED1, 16'hFED3, 16'hFED4, 16'hFED2};
            8'd162: return {1'b1, 16'hFED5, 16'hFED7, 16'hFED8, 16'hFED6};
            8'd163: return {1'b1, 16'hFED9, 16'hFEDB, 16'hFEDC, 16'hFEDA};
            8'd164: return {1'b1, 16'hFEDD, 16'hFEDF, 16'hFEE0, 16'hFEDE};
            8'd165: return {1'b1, 16'hFEE1, 16'hFEE3, 16'hFEE4, 16'hFEE2};
            8'd228: return {1'b1, 16'hFEE5, 16'hFEE7, 16'hFEE8, 16'hFEE6};
            8'd167: return {1'b1, 16'hFEE9, 16'hFEEB, 16'hFEEC, 16'hFEEA};
            8'd168: return {1'b1, 16'hFEED, 16'hFEED, 16'hFEEE, 16'hFEEE};
            8'd169: return {1'b1, 16'hFEEF, 16'hFEEF, 16'hFEF0, 16'hFEF0};
            8'd170: return {1'b1, 16'hFEF1, 16'hFEF3, 16'hFEF4, 16'hFEF2};
            8'd172: return {1'b1, 16'hFBFC, 16'hFBFE, 16'hFBFF, 16'hFBFD};
            8'd141: return {1'b1, 16'hFB7A, 16'hFB7C, 16'hFB7D, 16'hFB7B};
            8'd222: return {1'b1, 16'hFB56, 16'hFB58, 16'hFB59, 16'hFB57};
            8'd144: return {1'b1, 16'hFB92, 16'hFB94, 16'hFB95, 16'hFB93};
            8'd201: return {1'b1, 16'hFB8E, 16'hFB90, 16'hFB91, 16'hFB8F};
            8'd32:  return {1'b1, 16'h0020, 16'h0020, 16'h0020, 16'h0020};
            8'd44:  return {1'b1, 16'h060C, 16'h060C, 16'h060C, 16'h060C};
            8'd20:  return {1'b1, 16'h200C, 16'h200C, 16'h200C, 16'h200C};
            8'd58:  return {1'b1, 16'h003A, 16'h003A, 16'h003A, 16'h003A};
            8'd187: return {1'b1, 16'h061B, 16'h061B, 16'h061B, 16'h061B};
            8'd46:  return {1'b1, 16'h002E, 16'h002E, 16'h002E, 16'h002E};
            8'd191: return {1'b1, 16'h061F, 16'h061F, 16'h061F, 16'h061F};
            8'd48:  return {1'b1, 16'h06F0, 16'h06F0, 16'h06F0, 16'h06F0};
            8'd49:  return {1'b1, 16'h06F1, 16'h06F1, 16'h06F1, 16'h06F1};
            8'd50:  return {1'b1, 16'h06F2, 16'h06F2, 16'h06F2, 16'h06F2};
            8'd51:  return {1'b1, 16'h06F3, 16'h06F3, 16'h06F3, 16'h06F3};
            8'd52:  return {1'b1, 16'h06F4, 16'h06F4, 16'h06F4, 16'h06F4};
            8'd53:  return {1'b1, 16'h06F5, 16'h06F5, 16'h06F5, 16'h06F5};
            8'd54:  return {1'b1, 16'h06F6, 16'h06F6, 16'h06F6, 16'h06F6};
            8'd55:  return {1'b1, 16'h06F7, 16'h06F7, 16'h06F7, 16'h06F7};
            8'd56:  return {1'b1, 16'h06F8, 16'h06F8, 16'h06F8, 16'h06F8};
            8'd57:  return {1'b1, 16'h06F9, 16'h06F9, 16'h06F9, 16'h06F9};
            8'd41:  return {1'b1, 16'h0028, 16'h0028, 16'h0028, 16'h0028};
            8'd40:  return {1'b1, 16'h0029, 16'h0029, 16'h0029, 16'h0029};
            default: return {1'b0, 64'd0};
        endcase
    endfunction

    // Shapes one character and encodes the chosen form as UTF-8. A code that
    // is not in the table comes back as one raw byte with hit cleared.
    function automatic shaped_t shape(input logic [7:0] prev, input logic [7:0] code,
                                      input logic [7:0] next);
        logic [64:0] row;
        form_t       form;
        logic [15:0] cp;
        shaped_t     s;
        row  = glyph_row(code);
        form = in_set1(prev) ? (in_set2(next) ? FORM_ISOLATED : FORM_INITIAL)
                             : (in_set2(next) ? FORM_FINAL : FORM_MEDIAL);
        unique case (form)
            FORM_ISOLATED: cp = row[63:48];
            FORM_INITIAL:  cp = row[47:32];
            FORM_MEDIAL:   cp = row[31:16];
            FORM_FINAL:    cp = row[15:0];
            default:       cp = row[63:48];
        endcase
        s.hit   = row[64];
        s.bytes = '0;
        if (!row[64])
        begin
            s.len      = 2'd1;
            s.bytes[0] = code;
        end
        else if (cp < 16'h0080)
        begin
            s.len      = 2'd1;
            s.bytes[0] = cp[7:0];
        end
        else if (cp < 16'h0800)
        begin
            s.len      = 2'd2;
            s.bytes[0] = {3'b110, cp[10:6]};
            s.bytes[1] = {2'b10, cp[5:0]};
        end
        else
        begin
            s.len      = 2'd3;
            s.bytes[0] = {4'b1110, cp[15:12]};
            s.bytes[1] = {2'b10, cp[11:6]};
            s.bytes[2] = {2'b10, cp[5:0]};
        end
        return s;
    endfunction

endpackage

### src/arabic_persian_contextual_shaper.sv
// ----------------------------------------------------------------------------
// arabic_persian_contextual_shaper
// Streams UTF-8 Arabic and Persian text and emits contextually shaped glyphs.
// ----------------------------------------------------------------------------
// The shaper takes one UTF-8 word of text per cycle when not stalled and
// returns the shaped text as UTF-8 words, one per cycle unless out_stall is
// high. Each character is held until the next one arrives, so its output
// appears one character later; text_last on the final input word flushes
// the held character, marks the last output word with text_done and
// returns the block to its reset state for a new string. Input is accepted
// every cycle while the two-entry queue between the shaping front and the
// output serialiser has room; the output side sends one word per cycle
// unless stalled, so the output serialiser sets the sustained rate for a
// typical Arabic character (two input words, three output words). Codes not
// found in the glyph table leave as one raw word. Strings are not reversed.
module arabic_persian_contextual_shaper
    import apcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       text_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] glyph_byte,
    output logic       char_last,
    output logic       text_done
);

    logic        accept;
    logic        push;
    logic        pop;
    logic        full;
    logic        head_valid;
    apcs_entry_t push_entry;
    apcs_entry_t head_entry;

    // The stall comes straight from the queue fill level, so an input word
    // is taken whenever a free slot exists for what it might produce.
    assign in_stall = full;
    assign accept   = in_valid && !full;

    apcs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text_byte),
        .text_last (text_last),
        .push      (push),
        .entry     (push_entry)
    );

    apcs_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    apcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .glyph_byte (glyph_byte),
        .char_last  (char_last),
        .text_done  (text_done)
    );

endmodule

### src/apcs_front.sv
// ----------------------------------------------------------------------------
// apcs_front
// Decodes input words into characters, shapes them against their neighbours
// and packs every output word that one input word causes into one entry.
// ----------------------------------------------------------------------------
module apcs_front
    import apcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  text_byte,
    input  logic        text_last,
    output logic        push,
    output apcs_entry_t entry
);

    logic [7:0] prev_code_reg, prev_code_next;
    logic [7:0] pending_code_reg, pending_code_next;
    logic       pending_valid_reg, pending_valid_next;
    logic [7:0] lead_hold_reg, lead_hold_next;
    logic       lead_wait_reg, lead_wait_next;

    logic       have;
    logic [7:0] code;
    logic       first_v, second_v;
    shaped_t    first_s, second_s;
    logic [7:0] prev_mid;
    logic [7:0] tail_code;
    logic [1:0] len0, len1;

    always_comb
    begin
        have           = 1'b0;
        code           = '0;
        lead_hold_next = lead_hold_reg;
        lead_wait_next = lead_wait_reg;
        if (lead_wait_reg)
        begin
            code           = decode_pair(lead_hold_reg, text_byte);
            lead_wait_next = 1'b0;
            have           = 1'b1;
        end
        else if (text_byte[7])
        begin
            if (text_last)
            begin
                code = decode_pair(text_byte, 8'd0);
                have = 1'b1;
            end
            else
            begin
                lead_hold_next = text_byte;
                lead_wait_next = 1'b1;
            end
        end
        else
        begin
            code = text_byte;
            have = 1'b1;
        end

        // The held character is shaped once its look-ahead is known.
        first_v  = have && pending_valid_reg;
        first_s  = shape(prev_code_reg, pending_code_reg, code);
        prev_mid = (first_v && first_s.hit) ? pending_code_reg : prev_code_reg;

        // At the end of a string the last held character sees a NUL.
        tail_code = have ? code : pending_code_reg;
        second_v  = text_last && (have || pending_valid_reg);
        second_s  = shape(prev_mid, tail_code, 8'd0);

        pending_code_next  = have ? code : pending_code_reg;
        pending_valid_next = have || pending_valid_reg;
        prev_code_next     = (second_v && second_s.hit) ? tail_code : prev_mid;
        if (text_last)
        begin
            prev_code_next     = CodeSpace;
            pending_code_next  = '0;
            pending_valid_next = 1'b0;
            lead_hold_next     = '0;
            lead_wait_next     = 1'b0;
        end
    end

    always_comb
    begin
        len0        = first_v ? first_s.len : 2'd0;
        len1        = second_v ? second_s.len : 2'd0;
        entry.count = 3'(len0) + 3'(len1);
        entry.done  = text_last;
        entry.bytes = '0;
        entry.lasts = '0;
        for (int k = 0; k < MaxWords; k++)
        begin
            if (k < int'(len0))
            begin
                entry.bytes[k] = first_s.bytes[2'(k)];
                entry.lasts[k] = (k == int'(len0) - 1);
            end
            else if (k - int'(len0) < int'(len1))
            begin
                entry.bytes[k] = second_s.bytes[2'(k - int'(len0))];
                entry.lasts[k] = (k - int'(len0) == int'(len1) - 1);
            end
        end
        push = accept && (first_v || second_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_code_reg     <= CodeSpace;
            pending_code_reg  <= '0;
            pending_valid_reg <= 1'b0;
            lead_hold_reg     <= '0;
            lead_wait_reg     <= 1'b0;
        end
        else if (accept)
        begin
            prev_code_reg     <= prev_code_next;
            pending_code_reg  <= pending_code_next;
            pending_valid_reg <= pending_valid_next;
            lead_hold_reg     <= lead_hold_next;
            lead_wait_reg     <= lead_wait_next;
        end
    end

endmodule

### src/apcs_fifo.sv
// ----------------------------------------------------------------------------
// apcs_fifo
// Two-entry queue between the shaping front and the serialising back.
// ----------------------------------------------------------------------------
module apcs_fifo
    import apcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  apcs_entry_t push_entry,
    input  logic        pop,
    output logic        full,
    output logic        head_valid,
    output apcs_entry_t head_entry
);

    apcs_entry_t slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    always_comb
    begin
        full        = (count_reg == 2'd2);
        head_valid  = (count_reg != 2'd0);
        head_entry  = slot_reg[rd_ptr_reg];
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/apcs_back.sv
// ----------------------------------------------------------------------------
// apcs_back
// Sends the head entry's words from a register, one a cycle unless stalled.
// ----------------------------------------------------------------------------
module apcs_back
    import apcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  apcs_entry_t head_entry,
    output logic        pop,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [7:0]  glyph_byte,
    output logic        char_last,
    output logic        text_done
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] glyph_byte_reg;
    logic       char_last_reg;
    logic       text_done_reg;
    logic [2:0] idx_reg, idx_next;
    logic       load;
    logic       at_end;

    always_comb
    begin
        load           = head_valid && (!out_valid_reg || !out_stall);
        at_end         = (idx_reg == head_entry.count - 3'd1);
        pop            = load && at_end;
        idx_next       = load ? (at_end ? 3'd0 : idx_reg + 3'd1) : idx_reg;
        out_valid_next = load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            glyph_byte_reg <= head_entry.bytes[idx_reg];
            char_last_reg  <= head_entry.lasts[idx_reg];
            text_done_reg  <= head_entry.done && at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign glyph_byte = glyph_byte_reg;
    assign char_last  = char_last_reg;
    assign text_done  = text_done_reg;

endmodule

### src/apcs_checker.sv
// ----------------------------------------------------------------------------
// apcs_checker
// Port-level checks on the output stream of the contextual shaper.
// ----------------------------------------------------------------------------
`include "arabic_persian_contextual_shaper_macros.svh"

module apcs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] glyph_byte,
    input logic       char_last,
    input logic       text_done
);

    // The end of a string is always the end of a character.
    `APCS_ASSERT_SAME(a_done_ends_char, out_valid && text_done, char_last)

    // Only multi-word glyphs leave a character open, and those words are non-ASCII.
    `APCS_ASSERT_SAME(a_open_char_high, out_valid && !char_last, glyph_byte[7])

    // The rest of a character follows straight after an accepted word.
    `APCS_ASSERT_NEXT(a_char_unbroken, out_valid && !char_last && !out_stall, out_valid)

    // A stalled word holds.
    `APCS_ASSERT_NEXT(a_stall_holds, out_valid && out_stall,
                      out_valid && $stable(glyph_byte) && $stable(char_last))

endmodule

bind arabic_persian_contextual_shaper apcs_checker u_apcs_checker (.*);

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Arabic and Persian contextual shaper.
// ----------------------------------------------------------------------------
// Strings of UTF-8 words are fed through a queue-driven sender. A predictor
// of the shaper's behaviour works out the glyph words each accepted input
// word should cause. A clocked monitor compares every accepted output word
// against the oldest expected word.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apcs_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] text_byte;
    logic       text_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] glyph_byte;
    logic       char_last;
    logic       text_done;

    // One output word, as the shaper should send it.
    typedef struct packed {
        logic [7:0] glyph;
        logic       clast;
        logic       done;
    } glyph_word_t;

    // One input word waiting to be offered.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_word_t;

    text_word_t  pending_words[$];
    glyph_word_t expected_glyphs[$];

    int mismatch_count;
    int words_sent;
    int glyphs_seen;
    int strings_sent;

    // Idling percentages; the stimulus process changes them between phases.
    int send_idle_pct;
    int recv_stall_pct;

    // Long receiver hold-off, started by the stimulus and timed on its own.
    bit hold_off_go;
    bit hold_off_active;

    // Predictor state, kept apart from the block.
    logic [7:0] last_shaped;
    logic [7:0] held_code;
    logic       held_valid;
    logic [7:0] lead_byte;
    logic       lead_pending;

    arabic_persian_contextual_shaper u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .text_last  (text_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .glyph_byte (glyph_byte),
        .char_last  (char_last),
        .text_done  (text_done)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit joins_after(input logic [7:0] c);
        case (c)
            8'd32, 8'd0, 8'd199, 8'd194, 8'd207, 8'd208, 8'd209, 8'd210, 8'd184,
            8'd168, 8'd191, 8'd40, 8'd41, 8'd46, 8'd33, 8'd44, 8'd58, 8'd248:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic bit breaks_before(input logic [7:0] c);
        case (c)
            8'd32, 8'd0, 8'd191, 8'd40, 8'd41, 8'd46, 8'd33, 8'd44, 8'd58, 8'd248:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // Forms in the order isolated, initial, medial, final. Returns 0 on a miss.
    function automatic bit lookup_forms(input logic [7:0] c, output logic [15:0] f [4]);
        logic [15:0] base;
        base = 16'h0;
        f[0] = 16'h0; f[1] = 16'h0; f[2] = 16'h0; f[3] = 16'h0;
        case (c)
            8'd193: begin f[0]=16'hFE80; f[1]=16'hFE80; f[2]=16'hFE80; f[3]=16'hFE80; end
            8'd194: begin f[0]=16'hFE81; f[1]=16'hFE81; f[2]=16'hFE82; f[3]=16'hFE82; end
            8'd195: begin f[0]=16'hFE83; f[1]=16'hFE83; f[2]=16'hFE84; f[3]=16'hFE84; end
            8'd196: begin f[0]=16'hFE85; f[1]=16'hFE85; f[2]=16'hFE86; f[3]=16'hFE86; end
            8'd197: begin f[0]=16'hFE87; f[1]=16'hFE87; f[2]=16'hFE88; f[3]=16'hFE88; end
            8'd198: begin f[0]=16'hFE89; f[1]=16'hFE8B; f[2]=16'hFE8C; f[3]=16'hFE8A; end
            8'd199: begin f[0]=16'hFE8D; f[1]=16'hFE8D; f[2]=16'hFE8E; f[3]=16'hFE8E; end
            8'd200: base = 16'hFE8F;
            8'd202: base = 16'hFE95;
            8'd203: base = 16'hFE99;
            8'd204: base = 16'hFE9D;
            8'd205: base = 16'hFEA1;
            8'd206: base = 16'hFEA5;
            8'd207: begin f[0]=16'hFEA9; f[1]=16'hFEA9; f[2]=16'hFEAA; f[3]=16'hFEAA; end
            8'd208: begin f[0]=16'hFEAB; f[1]=16'hFEAB; f[2]=16'hFEAC; f[3]=16'hFEAC; end
            8'd209: begin f[0]=16'hFEAD; f[1]=16'hFEAD; f[2]=16'hFEAE; f[3]=16'hFEAE; end
            8'd210: begin f[0]=16'hFEAF; f[1]=16'hFEAF; f[2]=16'hFEB0; f[3]=16'hFEB0; end
            8'd184: begin f[0]=16'hFB8A; f[1]=16'hFB8A; f[2]=16'hFB8B; f[3]=16'hFB8B; end
            8'd211: base = 16'hFEB1;
            8'd212: base = 16'hFEB5;
            8'd213: base = 16'hFEB9;
            8'd214: base = 16'hFEBD;
            8'd215: base = 16'hFEC1;
            8'd216: base = 16'hFEC5;
            8'd217: base = 16'hFEC9;
            8'd218: base = 16'hFECD;
            8'd160: begin f[0]=16'h0640; f[1]=16'h0640; f[2]=16'h0640; f[3]=16'h0640; end
            8'd161: base = 16'hFED1;
            8'd162: base = 16'hFED5;
            8'd163: base = 16'hFED9;
            8'd164: base = 16'hFEDD;
            8'd165: base = 16'hFEE1;
            8'd228: base = 16'hFEE5;
            8'd167: base = 16'hFEE9;
            8'd168: begin f[0]=16'hFEED; f[1]=16'hFEED; f[2]=16'hFEEE; f[3]=16'hFEEE; end
            8'd169: begin f[0]=16'hFEEF; f[1]=16'hFEEF; f[2]=16'hFEF0; f[3]=16'hFEF0; end
            8'd170: base = 16'hFEF1;
            8'd172: base = 16'hFBFC;
            8'd141: base = 16'hFB7A;
            8'd222: base = 16'hFB56;
            8'd144: base = 16'hFB92;
            8'd201: base = 16'hFB8E;
            8'd32:  begin f[0]=16'h0020; f[1]=16'h0020; f[2]=16'h0020; f[3]=16'h0020; end
            8'd44:  begin f[0]=16'h060C; f[1]=16'h060C; f[2]=16'h060C; f[3]=16'h060C; end
            8'd20:  begin f[0]=16'h200C; f[1]=16'h200C; f[2]=16'h200C; f[3]=16'h200C; end
            8'd58:  begin f[0]=16'h003A; f[1]=16'h003A; f[2]=16'h003A; f[3]=16'h003A; end
            8'd187: begin f[0]=16'h061B; f[1]=16'h061B; f[2]=16'h061B; f[3]=16'h061B; end
            8'd46:  begin f[0]=16'h002E; f[1]=16'h002E; f[2]=16'h002E; f[3]=16'h002E; end
            8'd191: begin f[0]=16'h061F; f[1]=16'h061F; f[2]=16'h061F; f[3]=16'h061F; end
            8'd41:  begin f[0]=16'h0028; f[1]=16'h0028; f[2]=16'h0028; f[3]=16'h0028; end
            8'd40:  begin f[0]=16'h0029; f[1]=16'h0029; f[2]=16'h0029; f[3]=16'h0029; end
            default:
            begin
                // Persian digits sit in one contiguous run.
                if (c >= 8'd48 && c <= 8'd57)
                begin
                    f[0] = 16'h06F0 + 16'(c - 8'd48);
                    f[1] = f[0]; f[2] = f[0]; f[3] = f[0];
                end
                else
                begin
                    return 1'b0;
                end
            end
        endcase
        // Four-form letters follow the isolated, final, initial, medial layout.
        if (base != 16'h0)
        begin
            f[0] = base;
            f[3] = base + 16'd1;
            f[1] = base + 16'd2;
            f[2] = base + 16'd3;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] pair_to_code(input logic [7:0] lead, input logic [7:0] trail);
        logic [7:0] t;
        logic [7:0] c;
        bit         gaf_row;
        t = lead + 8'd32;
        c = trail + 8'd32;
        gaf_row = (t == 8'd218) || (t == 8'd250);
        if (c == 8'd207)
        begin
            if (gaf_row)
            begin
                c = 8'd144;
            end
        end
        else if (c == 8'd166)
        begin
            c = gaf_row ? 8'd141 : 8'd228;
        end
        if (c == 8'd172 && (t == 8'd248 || t == 8'd32))
        begin
            c = 8'd44;
        end
        return c;
    endfunction

    function automatic void push_glyph(input logic [7:0] g, input logic cl);
        glyph_word_t w;
        w.glyph = g;
        w.clast = cl;
        w.done  = 1'b0;
        expected_glyphs = {expected_glyphs, w};
    endfunction

    // Shapes one held character against its look-ahead.
    function automatic void shape_held(input logic [7:0] c, input logic [7:0] next);
        logic [15:0] f [4];
        logic [15:0] cp;
        int          col;
        if (joins_after(last_shaped))
        begin
            col = breaks_before(next) ? 0 : 1;
        end
        else
        begin
            col = breaks_before(next) ? 3 : 2;
        end
        if (!lookup_forms(c, f))
        begin
            push_glyph(c, 1'b1);
            return;
        end
        cp = f[col];
        if (cp < 16'h0080)
        begin
            push_glyph(cp[7:0], 1'b1);
        end
        else if (cp < 16'h0800)
        begin
            push_glyph({3'b110, cp[10:6]}, 1'b0);
            push_glyph({2'b10, cp[5:0]}, 1'b1);
        end
        else
        begin
            push_glyph({4'b1110, cp[15:12]}, 1'b0);
            push_glyph({2'b10, cp[11:6]}, 1'b0);
            push_glyph({2'b10, cp[5:0]}, 1'b1);
        end
        last_shaped = c;
    endfunction

    function automatic void clear_predictor();
        last_shaped  = 8'd32;
        held_code    = 8'd0;
        held_valid   = 1'b0;
        lead_byte    = 8'd0;
        lead_pending = 1'b0;
    endfunction

    function automatic void predict_word(input logic [7:0] b, input logic last);
        bit         have;
        logic [7:0] c;
        int         before_n;
        have = 1'b0;
        c = 8'd0;
        before_n = expected_glyphs.size();
        if (lead_pending)
        begin
            c = pair_to_code(lead_byte, b);
            lead_pending = 1'b0;
            have = 1'b1;
        end
        else if (b >= 8'd128)
        begin
            if (last)
            begin
                c = pair_to_code(b, 8'd0);
                have = 1'b1;
            end
            else
            begin
                lead_byte = b;
                lead_pending = 1'b1;
            end
        end
        else
        begin
            c = b;
            have = 1'b1;
        end
        if (have)
        begin
            if (held_valid)
            begin
                shape_held(held_code, c);
            end
            held_code = c;
            held_valid = 1'b1;
        end
        if (last)
        begin
            if (held_valid)
            begin
                shape_held(held_code, 8'd0);
            end
            clear_predictor();
            if (expected_glyphs.size() > before_n)
            begin
                expected_glyphs[expected_glyphs.size() - 1].done = 1'b1;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Sender: offers queued words, idling at random between them.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            text_byte <= 8'd0;
            text_last <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_word(text_byte, text_last);
                words_sent++;
                if (text_last)
                begin
                    strings_sent++;
                end
            end
            // A stalled word stays put; otherwise choose the next one.
            if (!(in_valid && in_stall))
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    text_word_t w;
                    w = pending_words.pop_front();
                    in_valid  <= 1'b1;
                    text_byte <= w.data;
                    text_last <= w.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Hold-off timer: once started, keeps the receiver stalled while it counts.
    // ------------------------------------------------------------------
    always
    begin
        @(posedge hold_off_go);
        @(posedge clk);
        hold_off_active <= 1'b1;
        repeat (60) @(posedge clk);
        hold_off_active <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Receiver: stalls at random, and for a long stretch when asked.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                glyph_word_t w;
                glyphs_seen++;
                if (expected_glyphs.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word %02h", glyph_byte));
                end
                else
                begin
                    w = expected_glyphs.pop_front();
                    if (glyph_byte !== w.glyph)
                    begin
                        report_mismatch($sformatf("glyph_byte %02h, wanted %02h",
                                                  glyph_byte, w.glyph));
                    end
                    if (char_last !== w.clast)
                    begin
                        report_mismatch($sformatf("char_last %b, wanted %b",
                                                  char_last, w.clast));
                    end
                    if (text_done !== w.done)
                    begin
                        report_mismatch($sformatf("text_done %b, wanted %b",
                                                  text_done, w.done));
                    end
                end
            end
            if (hold_off_active)
            begin
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_word(input logic [7:0] b, input logic last);
        text_word_t w;
        w.data = b;
        w.last = last;
        pending_words = {pending_words, w};
    endtask

    // Picks one plausible character and queues its bytes.
    task automatic queue_random_char(input bit last);
        int pick;
        logic [7:0] lead;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            // Arabic block letters: lead D8 or D9, or the gaf/cheh rows DA and DB.
            case ($urandom_range(3))
                0: lead = 8'hD8;
                1: lead = 8'hD9;
                2: lead = 8'hDA;
                default: lead = 8'hDB;
            endcase
            queue_word(lead, 1'b0);
            queue_word(8'h80 | 8'($urandom_range(63)), last);
        end
        else if (pick < 80)
        begin
            // Spaces and punctuation that break a joined run, and digits.
            case ($urandom_range(5))
                0: queue_word(8'd32, last);
                1: queue_word(8'd46, last);
                2: queue_word(8'd33, last);
                3: queue_word(8'd40, last);
                4: queue_word(8'd58, last);
                default: queue_word(8'd48 + 8'($urandom_range(9)), last);
            endcase
        end
        else if (pick < 92)
        begin
            queue_word(8'($urandom_range(127)), last);
        end
        else
        begin
            // Any lead with any trail, zero included.
            queue_word(8'($urandom_range(255, 128)), 1'b0);
            queue_word(8'($urandom_range(255)), last);
        end
    endtask

    task automatic queue_random_string();
        int chars;
        chars = $urandom_range(8, 1);
        for (int i = 0; i < chars; i++)
        begin
            queue_random_char(i == chars - 1);
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_glyphs.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int words);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = words_sent + words;
        while (words_sent + pending_words.size() < target)
        begin
            // Mostly well-formed strings, with some loose noise bytes.
            if ($urandom_range(9) == 0)
            begin
                queue_word(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            else
            begin
                queue_random_string();
            end
        end
        while (pending_words.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        mismatch_count = 0;
        words_sent     = 0;
        glyphs_seen    = 0;
        strings_sent   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_go    = 1'b0;
        clear_predictor();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: "salam" style text, gaf, cheh, noon, the Arabic comma,
        // a code missing from the table, teh marbuta, a zero byte, a lead
        // byte marked last and a trail byte of zero.
        queue_word(8'hD8, 1'b0); queue_word(8'hB3, 1'b0);
        queue_word(8'hD9, 1'b0); queue_word(8'h84, 1'b0);
        queue_word(8'hD8, 1'b0); queue_word(8'hA7, 1'b0);
        queue_word(8'hD9, 1'b0); queue_word(8'h85, 1'b1);
        queue_word(8'hDA, 1'b0); queue_word(8'hAF, 1'b0);
        queue_word(8'hDA, 1'b0); queue_word(8'h86, 1'b0);
        queue_word(8'hD9, 1'b0); queue_word(8'h86, 1'b0);
        queue_word(8'hD8, 1'b0); queue_word(8'h8C, 1'b0);
        queue_word(8'hD8, 1'b0); queue_word(8'hA9, 1'b0);
        queue_word(8'd0, 1'b0);
        queue_word(8'd127, 1'b0);
        queue_word(8'hFF, 1'b0); queue_word(8'd0, 1'b0);
        queue_word(8'hFF, 1'b1);
        queue_word(8'd32, 1'b1);
        wait_drained();

        // No idling on either side.
        run_phase(0, 0, 90);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering words.
        hold_off_go = 1'b1;
        run_phase(0, 0, 30);
        wait_drained();

        run_phase(71, 0, 80);
        run_phase(0, 71, 80);
        // Sender pauses until every expected word has arrived.
        wait_drained();
        run_phase(19, 19, 110);
        wait_drained();

        $display("Sent %0d text words in %0d strings and checked %0d glyph words.",
                 words_sent, strings_sent, glyphs_seen);
        $display("Covered all shaping forms, special decodes and four idling phases.");
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Safety net in case the shaper hangs.
    initial
    begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
